>>> design/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants for the magnetometer hard-iron and soft-iron
// correction core.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

  localparam int AXES      = 3;
  localparam int BYTE_W    = 8;
  localparam int RAW_W     = 16;  // assembled sensor count
  localparam int FRAC_W    = 4;   // fraction bits of the corrected values
  localparam int OFFS_W    = 20;  // hard-iron offset
  localparam int DIFF_W    = 21;  // raw * 16 - offset
  localparam int COEF_W    = 16;  // Q2.14 soft-iron coefficient
  localparam int ROW_W     = 48;  // three coefficients per row
  localparam int PROD_W    = COEF_W + DIFF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int COEF_FRAC = 14;
  localparam int SHR_W     = SUM_W - COEF_FRAC;
  localparam int CAL_W     = 24;

  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;

  // Register indexes on the configuration port (8 bytes apart).
  localparam logic [2:0] REG_OFFS_X = 3'd0;
  localparam logic [2:0] REG_OFFS_Y = 3'd1;
  localparam logic [2:0] REG_OFFS_Z = 3'd2;
  localparam logic [2:0] REG_ROW_0  = 3'd3;
  localparam logic [2:0] REG_ROW_1  = 3'd4;
  localparam logic [2:0] REG_ROW_2  = 3'd5;

  // Identity matrix after reset.
  localparam logic [ROW_W-1:0] ROW_0_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_1_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_2_RST = 48'h4000_0000_0000;

  localparam logic signed [SHR_W-1:0] CAL_MAX = SHR_W'(24'sh7F_FFFF);
  localparam logic signed [SHR_W-1:0] CAL_MIN = SHR_W'(-25'sd8388608);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [CAL_W-1:0] cal_t;

  typedef struct packed {
    logic [AXES-1:0][OFFS_W-1:0] offs;
    logic [AXES-1:0][ROW_W-1:0]  rows;
  } cal_cfg_t;

endpackage

`default_nettype wire

>>> design/magnetometer_iron_calibration_core.sv
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_core
// Hard-iron and soft-iron correction of three-axis magnetometer samples.
// ----------------------------------------------------------------------------
// A sample (six sensor bytes) is taken at every clock edge where start is
// high; busy is always low, so a new sample may be issued every cycle. The
// result beat appears on the out_ ports once it has passed every stage, marked by
// out_valid for exactly one cycle, in the order the samples came in: one
// stage removes the offset, one forms the nine matrix products and one sums,
// shifts and saturates each row. The receiver must take every beat when it
// is shown. Configuration registers sit 8 bytes apart on the APB port and are
// to be written only while no sample is in flight.
`default_nettype none

module magnetometer_iron_calibration_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire mic_pkg::byte_t             in_x_low_byte,
  input  wire mic_pkg::byte_t             in_x_high_byte,
  input  wire mic_pkg::byte_t             in_y_low_byte,
  input  wire mic_pkg::byte_t             in_y_high_byte,
  input  wire mic_pkg::byte_t             in_z_low_byte,
  input  wire mic_pkg::byte_t             in_z_high_byte,
  output logic                            out_valid,
  output mic_pkg::raw_t                   out_raw_x,
  output mic_pkg::raw_t                   out_raw_y,
  output mic_pkg::raw_t                   out_raw_z,
  output mic_pkg::cal_t                   out_cal_x,
  output mic_pkg::cal_t                   out_cal_y,
  output mic_pkg::cal_t                   out_cal_z,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mic_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mic_pkg::DATA_W-1:0] pwdata,
  output logic      [mic_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import mic_pkg::*;

  cal_cfg_t cfg;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mic_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mic_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (accept),
    .in_x_low_byte  (in_x_low_byte),
    .in_x_high_byte (in_x_high_byte),
    .in_y_low_byte  (in_y_low_byte),
    .in_y_high_byte (in_y_high_byte),
    .in_z_low_byte  (in_z_low_byte),
    .in_z_high_byte (in_z_high_byte),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_raw_x      (out_raw_x),
    .out_raw_y      (out_raw_y),
    .out_raw_z      (out_raw_z),
    .out_cal_x      (out_cal_x),
    .out_cal_y      (out_cal_y),
    .out_cal_z      (out_cal_z)
  );

endmodule

`default_nettype wire

>>> design/mic_cfg_regs.sv
// ----------------------------------------------------------------------------
// mic_cfg_regs
// Register file behind the APB-style port: three hard-iron offsets and
// three soft-iron matrix rows.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_cfg_regs (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [mic_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mic_pkg::DATA_W-1:0] pwdata,
  output logic      [mic_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mic_pkg::cal_cfg_t           cfg
);
  import mic_pkg::*;

  logic [AXES-1:0][OFFS_W-1:0] offs_r, offs_nxt;
  logic [AXES-1:0][ROW_W-1:0]  rows_r, rows_nxt;
  logic [2:0]                  idx;
  logic                        wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    offs_nxt = offs_r;
    rows_nxt = rows_r;
    if (wr_en) begin
      unique case (idx)
        REG_OFFS_X: offs_nxt[0] = pwdata[OFFS_W-1:0];
        REG_OFFS_Y: offs_nxt[1] = pwdata[OFFS_W-1:0];
        REG_OFFS_Z: offs_nxt[2] = pwdata[OFFS_W-1:0];
        REG_ROW_0:  rows_nxt[0] = pwdata[ROW_W-1:0];
        REG_ROW_1:  rows_nxt[1] = pwdata[ROW_W-1:0];
        REG_ROW_2:  rows_nxt[2] = pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offs_r <= '0;
      rows_r <= {ROW_2_RST, ROW_1_RST, ROW_0_RST};
    end else begin
      offs_r <= offs_nxt;
      rows_r <= rows_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFS_X: prdata = DATA_W'(offs_r[0]);
      REG_OFFS_Y: prdata = DATA_W'(offs_r[1]);
      REG_OFFS_Z: prdata = DATA_W'(offs_r[2]);
      REG_ROW_0:  prdata = DATA_W'(rows_r[0]);
      REG_ROW_1:  prdata = DATA_W'(rows_r[1]);
      REG_ROW_2:  prdata = DATA_W'(rows_r[2]);
      default:    prdata = '0;
    endcase
  end

  assign cfg.offs = offs_r;
  assign cfg.rows = rows_r;

endmodule

`default_nettype wire

>>> design/mic_datapath.sv
// ----------------------------------------------------------------------------
// mic_datapath
// Three-stage correction pipeline: assemble and remove the hard-iron offset,
// form the nine matrix products, then sum, shift and saturate each row.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire mic_pkg::byte_t    in_x_low_byte,
  input  wire mic_pkg::byte_t    in_x_high_byte,
  input  wire mic_pkg::byte_t    in_y_low_byte,
  input  wire mic_pkg::byte_t    in_y_high_byte,
  input  wire mic_pkg::byte_t    in_z_low_byte,
  input  wire mic_pkg::byte_t    in_z_high_byte,
  input  wire mic_pkg::cal_cfg_t cfg,
  output logic                   out_valid,
  output mic_pkg::raw_t          out_raw_x,
  output mic_pkg::raw_t          out_raw_y,
  output mic_pkg::raw_t          out_raw_z,
  output mic_pkg::cal_t          out_cal_x,
  output mic_pkg::cal_t          out_cal_y,
  output mic_pkg::cal_t          out_cal_z
);
  import mic_pkg::*;

  // Stage 1: assembled counts and offset-corrected vector.
  logic                       v1_r;
  raw_t                       raw1_r   [AXES];
  raw_t                       raw1_nxt [AXES];
  logic signed [DIFF_W-1:0]   d1_r     [AXES];
  logic signed [DIFF_W-1:0]   d1_nxt   [AXES];

  // Stage 2: products.
  logic                       v2_r;
  raw_t                       raw2_r   [AXES];
  logic signed [PROD_W-1:0]   p2_r     [AXES][AXES];
  logic signed [PROD_W-1:0]   p2_nxt   [AXES][AXES];

  // Stage 3: results.
  logic                       v3_r;
  raw_t                       raw3_r   [AXES];
  cal_t                       cal3_r   [AXES];
  cal_t                       cal3_nxt [AXES];

  always_comb begin
    raw1_nxt[0] = {in_x_high_byte, in_x_low_byte};
    raw1_nxt[1] = {in_y_high_byte, in_y_low_byte};
    raw1_nxt[2] = {in_z_high_byte, in_z_low_byte};
    for (int a = 0; a < AXES; a++) begin
      d1_nxt[a] = DIFF_W'($signed({raw1_nxt[a], {FRAC_W{1'b0}}}))
                - DIFF_W'($signed(cfg.offs[a]));
    end
  end

  // Every row works on the same offset-corrected vector.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        p2_nxt[r][c] = PROD_W'($signed(cfg.rows[r][COEF_W*c +: COEF_W])) *
                       PROD_W'(d1_r[c]);
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SHR_W-1:0] shr;
    for (int r = 0; r < AXES; r++) begin
      sum = SUM_W'(p2_r[r][0]) + SUM_W'(p2_r[r][1]) + SUM_W'(p2_r[r][2]);
      // Dropping the low bits of a two's complement sum rounds toward minus infinity.
      shr = sum[SUM_W-1:COEF_FRAC];
      if (shr > CAL_MAX) begin
        cal3_nxt[r] = CAL_MAX[CAL_W-1:0];
      end else if (shr < CAL_MIN) begin
        cal3_nxt[r] = CAL_MIN[CAL_W-1:0];
      end else begin
        cal3_nxt[r] = shr[CAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    raw1_r <= raw1_nxt;
    d1_r   <= d1_nxt;
    raw2_r <= raw1_r;
    p2_r   <= p2_nxt;
    raw3_r <= raw2_r;
    cal3_r <= cal3_nxt;
  end

  assign out_valid = v3_r;
  assign out_raw_x = raw3_r[0];
  assign out_raw_y = raw3_r[1];
  assign out_raw_z = raw3_r[2];
  assign out_cal_x = cal3_r[0];
  assign out_cal_y = cal3_r[1];
  assign out_cal_z = cal3_r[2];

endmodule

`default_nettype wire

>>> design/mic_checker.sv
// ----------------------------------------------------------------------------
// mic_checker
// Port-level checks of the correction core: beat timing and raw pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire mic_pkg::byte_t      in_x_low_byte,
  input wire mic_pkg::byte_t      in_x_high_byte,
  input wire mic_pkg::byte_t      in_z_low_byte,
  input wire mic_pkg::byte_t      in_z_high_byte,
  input wire logic                out_valid,
  input wire mic_pkg::raw_t       out_raw_x,
  input wire mic_pkg::raw_t       out_raw_z
);
  import mic_pkg::*;

  // Every accepted sample produces a matching result beat.
  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("accepted sample produced no result beat");

  // No result beat without a matching accepted sample.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result beat without an accepted sample");

  a_raw_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_raw_x == $past({in_x_high_byte, in_x_low_byte}, 3))
    else $error("raw x does not match the sample bytes");

  a_raw_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_raw_z == $past({in_z_high_byte, in_z_low_byte}, 3))
    else $error("raw z does not match the sample bytes");

endmodule

bind magnetometer_iron_calibration_core mic_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_x_low_byte  (in_x_low_byte),
  .in_x_high_byte (in_x_high_byte),
  .in_z_low_byte  (in_z_low_byte),
  .in_z_high_byte (in_z_high_byte),
  .out_valid      (out_valid),
  .out_raw_x      (out_raw_x),
  .out_raw_z      (out_raw_z)
);

`default_nettype wire

>>> tb/mag_correction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mag_correction_checker
// Watches the sample, result and register ports of the magnetometer
// correction core, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
// The register mirror is kept by snooping completed APB writes, so the
// stimulus side needs no knowledge of the expected values.

module mag_correction_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  mic_pkg::byte_t                  in_x_low_byte,
  input  mic_pkg::byte_t                  in_x_high_byte,
  input  mic_pkg::byte_t                  in_y_low_byte,
  input  mic_pkg::byte_t                  in_y_high_byte,
  input  mic_pkg::byte_t                  in_z_low_byte,
  input  mic_pkg::byte_t                  in_z_high_byte,
  input  logic                            out_valid,
  input  mic_pkg::raw_t                   out_raw_x,
  input  mic_pkg::raw_t                   out_raw_y,
  input  mic_pkg::raw_t                   out_raw_z,
  input  mic_pkg::cal_t                   out_cal_x,
  input  mic_pkg::cal_t                   out_cal_y,
  input  mic_pkg::cal_t                   out_cal_z,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mic_pkg::ADDR_W-1:0]      paddr,
  input  logic [mic_pkg::DATA_W-1:0]      pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              readings_pending,
  output int                              beats_checked
);

  import mic_pkg::*;

  typedef struct packed {
    raw_t raw_x;
    raw_t raw_y;
    raw_t raw_z;
    cal_t cal_x;
    cal_t cal_y;
    cal_t cal_z;
  } mag_reading_t;

  logic signed [OFFS_W-1:0] hard_offs [AXES];
  logic [ROW_W-1:0]         soft_rows [AXES];
  mag_reading_t             expected_readings [$];

  initial begin
    mismatches       = 0;
    readings_pending = 0;
    beats_checked    = 0;
  end

  // Raw counts pass through; the corrected vector is M * (16 * raw - offset),
  // every row working on the same offset-corrected vector, then >>> 14 and
  // clamped to 24 bits.
  function automatic mag_reading_t correct_sample(input logic [5:0][7:0] sb);
    mag_reading_t             rd;
    logic signed [RAW_W-1:0]  rawv [AXES];
    logic signed [CAL_W-1:0]  calv [AXES];
    logic signed [COEF_W-1:0] cf;
    longint                   dv [AXES];
    longint                   acc;
    longint                   shr;
    for (int a = 0; a < AXES; a++) begin
      rawv[a] = {sb[2*a+1], sb[2*a]};
      dv[a]   = longint'(rawv[a]) * 16 - longint'(hard_offs[a]);
    end
    for (int r = 0; r < AXES; r++) begin
      acc = 0;
      for (int k = 0; k < AXES; k++) begin
        cf  = soft_rows[r][COEF_W*k +: COEF_W];
        acc = acc + longint'(cf) * dv[k];
      end
      shr = acc >>> COEF_FRAC;
      if (shr > 64'sd8388607)
        shr = 64'sd8388607;
      if (shr < -64'sd8388608)
        shr = -64'sd8388608;
      calv[r] = shr[CAL_W-1:0];
    end
    rd.raw_x = rawv[0];
    rd.raw_y = rawv[1];
    rd.raw_z = rawv[2];
    rd.cal_x = calv[0];
    rd.cal_y = calv[1];
    rd.cal_z = calv[2];
    return rd;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    mag_reading_t want;
    if (!rst_n) begin
      hard_offs[0] <= '0;
      hard_offs[1] <= '0;
      hard_offs[2] <= '0;
      soft_rows[0] <= ROW_0_RST;
      soft_rows[1] <= ROW_1_RST;
      soft_rows[2] <= ROW_2_RST;
      expected_readings.delete();
      readings_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_OFFS_X: hard_offs[0] <= pwdata[OFFS_W-1:0];
          REG_OFFS_Y: hard_offs[1] <= pwdata[OFFS_W-1:0];
          REG_OFFS_Z: hard_offs[2] <= pwdata[OFFS_W-1:0];
          REG_ROW_0:  soft_rows[0] <= pwdata[ROW_W-1:0];
          REG_ROW_1:  soft_rows[1] <= pwdata[ROW_W-1:0];
          REG_ROW_2:  soft_rows[2] <= pwdata[ROW_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_readings.push_back(correct_sample({in_z_high_byte, in_z_low_byte,
                                                    in_y_high_byte, in_y_low_byte,
                                                    in_x_high_byte, in_x_low_byte}));
      end
      if (out_valid) begin
        beats_checked++;
        if (expected_readings.size() == 0) begin
          $display("%0t: result beat with no sample outstanding, expected none, got raw %0d %0d %0d",
                   $time, out_raw_x, out_raw_y, out_raw_z);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("raw_x", want.raw_x, out_raw_x);
          check_field("raw_y", want.raw_y, out_raw_y);
          check_field("raw_z", want.raw_z, out_raw_z);
          check_field("cal_x", want.cal_x, out_cal_x);
          check_field("cal_y", want.cal_y, out_cal_y);
          check_field("cal_z", want.cal_z, out_cal_z);
        end
      end
      readings_pending <= expected_readings.size();
    end
  end

endmodule

>>> tb/magnetometer_iron_calibration_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_core_tb
// Sample stream and register stimulus for the magnetometer correction core.
// ----------------------------------------------------------------------------
// Directed samples at the count extremes under the reset, extreme and a
// full off-diagonal calibration come first, then random sample streams under
// a series of register settings. Random gaps and gap-free bursts shape the
// sample side; the checker beside the core predicts and compares.

module magnetometer_iron_calibration_core_tb;

  import mic_pkg::*;

  localparam int         PIPE_LATENCY = 3;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_PHASES = 8;
  localparam int         SAMPLES_PER_PHASE = 192;
  // Addresses beyond the register map, written to show they are ignored.
  localparam logic [2:0] UNMAPPED_LO = 3'd6;
  localparam logic [2:0] UNMAPPED_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  byte_t             in_x_low_byte = '0;
  byte_t             in_x_high_byte = '0;
  byte_t             in_y_low_byte = '0;
  byte_t             in_y_high_byte = '0;
  byte_t             in_z_low_byte = '0;
  byte_t             in_z_high_byte = '0;
  logic              out_valid;
  raw_t              out_raw_x;
  raw_t              out_raw_y;
  raw_t              out_raw_z;
  cal_t              out_cal_x;
  cal_t              out_cal_y;
  cal_t              out_cal_z;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int readings_pending;
  int beats_checked;
  int cycle_count = 0;
  int samples_sent = 0;
  int settings_loaded = 0;
  int reg_writes = 0;
  int unmapped_writes = 0;
  int burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magnetometer_iron_calibration_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_low_byte  (in_x_low_byte),
    .in_x_high_byte (in_x_high_byte),
    .in_y_low_byte  (in_y_low_byte),
    .in_y_high_byte (in_y_high_byte),
    .in_z_low_byte  (in_z_low_byte),
    .in_z_high_byte (in_z_high_byte),
    .out_valid      (out_valid),
    .out_raw_x      (out_raw_x),
    .out_raw_y      (out_raw_y),
    .out_raw_z      (out_raw_z),
    .out_cal_x      (out_cal_x),
    .out_cal_y      (out_cal_y),
    .out_cal_z      (out_cal_z),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  mag_correction_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_x_low_byte    (in_x_low_byte),
    .in_x_high_byte   (in_x_high_byte),
    .in_y_low_byte    (in_y_low_byte),
    .in_y_high_byte   (in_y_high_byte),
    .in_z_low_byte    (in_z_low_byte),
    .in_z_high_byte   (in_z_high_byte),
    .out_valid        (out_valid),
    .out_raw_x        (out_raw_x),
    .out_raw_y        (out_raw_y),
    .out_raw_z        (out_raw_z),
    .out_cal_x        (out_cal_x),
    .out_cal_y        (out_cal_y),
    .out_cal_z        (out_cal_z),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .readings_pending (readings_pending),
    .beats_checked    (beats_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** magnetometer_iron_calibration_core: FAILED **");
      $finish;
    end
  end

  // All tasks are entered and left just after a rising edge.
  task automatic issue_sample(input logic [5:0][7:0] sb);
    int gap;
    int pick;
    start          <= 1'b1;
    in_x_low_byte  <= sb[0];
    in_x_high_byte <= sb[1];
    in_y_low_byte  <= sb[2];
    in_y_high_byte <= sb[3];
    in_z_low_byte  <= sb[4];
    in_z_high_byte <= sb[5];
    do @(negedge clk); while (busy);
    @(posedge clk);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        gap = 0;
      else if (pick < 92)
        gap = $urandom_range(1, 3);
      else
        gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off the sample side until every outstanding beat has come out.
  task automatic wait_drain();
    start <= 1'b0;
    do @(negedge clk); while (readings_pending != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Junk above each register's width must not reach the datapath.
  task automatic load_config(input logic [2:0][OFFS_W-1:0] offs,
                             input logic [2:0][ROW_W-1:0] rows);
    logic [DATA_W-1:0] junk;
    for (int a = 0; a < AXES; a++) begin
      junk = {$urandom, $urandom};
      cfg_write(3'(REG_OFFS_X + a), {junk[DATA_W-1:OFFS_W], offs[a]});
    end
    for (int a = 0; a < AXES; a++) begin
      junk = {$urandom, $urandom};
      cfg_write(3'(REG_ROW_0 + a), {junk[DATA_W-1:ROW_W], rows[a]});
    end
    cfg_write(UNMAPPED_LO, {$urandom, $urandom});
    cfg_write(UNMAPPED_HI, {$urandom, $urandom});
    unmapped_writes += 2;
    settings_loaded++;
  endtask

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h4000;
      4:       return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [OFFS_W-1:0] random_offset();
    case ($urandom_range(0, 7))
      0:       return 20'h80000;
      1:       return 20'h7FFFF;
      2:       return 20'h00000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic byte_t random_byte();
    case ($urandom_range(0, 19))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0][OFFS_W-1:0] offs;
    logic [2:0][ROW_W-1:0]  rows;
    logic [5:0][7:0]        sb;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: identity matrix and no offset.
    issue_sample(48'h0000_0000_0000);
    issue_sample(48'hFFFF_FFFF_FFFF);
    issue_sample(48'h7FFF_7FFF_7FFF);
    issue_sample(48'h8000_8000_8000);
    issue_sample(48'h0001_8000_7FFF);
    issue_sample(48'h0100_00FF_FF00);
    issue_sample(48'h5A5A_A5A5_3C3C);

    // Largest positive offset with the most negative coefficients everywhere.
    wait_drain();
    load_config({3{20'h7FFFF}}, {9{16'h8000}});
    issue_sample(48'h8000_8000_8000);
    issue_sample(48'h7FFF_7FFF_7FFF);
    issue_sample(48'h0000_0000_0000);
    issue_sample(48'h7FFF_8000_7FFF);

    // Most negative offset with the largest positive coefficients.
    wait_drain();
    load_config({3{20'h80000}}, {9{16'h7FFF}});
    issue_sample(48'h7FFF_7FFF_7FFF);
    issue_sample(48'h8000_8000_8000);
    issue_sample(48'h0000_0000_0000);

    // Full matrix: each row must see the same offset-corrected vector.
    wait_drain();
    load_config({20'h00010, 20'hFFF00, 20'h00123},
                {{16'h4000, 16'h0C00, 16'hD000},
                 {16'hF800, 16'h4000, 16'h2000},
                 {16'h1000, 16'hE000, 16'h4000}});
    issue_sample(48'h0200_FE00_0100);
    issue_sample(48'hC000_4000_8001);
    issue_sample(48'h1234_5678_9ABC);
    issue_sample(48'hFEDC_BA98_7654);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drain();
      for (int a = 0; a < AXES; a++) begin
        offs[a] = random_offset();
        rows[a] = {random_coef(), random_coef(), random_coef()};
      end
      if (ph == 5) begin
        offs = '0;
        rows = {ROW_2_RST, ROW_1_RST, ROW_0_RST};
      end else if (ph == RANDOM_PHASES - 1) begin
        rows = '0;
      end
      load_config(offs, rows);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        for (int b = 0; b < 6; b++)
          sb[b] = random_byte();
        issue_sample(sb);
        // Let the pipeline empty once in the middle of a stream.
        if (ph == 0 && n == SAMPLES_PER_PHASE / 2)
          wait_drain();
      end
    end

    wait_drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    $display("Covered %0d samples under %0d register settings, %0d register writes",
             samples_sent, settings_loaded + 1, reg_writes);
    $display("(%0d of them to unmapped addresses); %0d result beats compared.",
             unmapped_writes, beats_checked);
    if (mismatches == 0 && readings_pending == 0) begin
      $display("** magnetometer_iron_calibration_core: PASSED **");
    end else begin
      $display("** magnetometer_iron_calibration_core: FAILED **");
    end
    $finish;
  end

endmodule
